[design/lpfd_pkg.sv]
// Shared types and constants for the length-prefixed frame deframer.
// Used by lpfd_apb_regs, lpfd_parser and length_prefixed_frame_deframer.
`default_nettype none

package lpfd_pkg;

    localparam int HEADER_BYTES  = 8;
    localparam int LENGTH_OFFSET = 7;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 9;
    localparam int ROLE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [POS_W-1:0] HEADER_END = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] LENGTH_POS = POS_W'(LENGTH_OFFSET);

    localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'd170;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST = 8'd255;

    // register index taken from the word address bit
    typedef enum logic
    {
        REG_START_BYTE  = 1'b0,
        REG_MAX_PAYLOAD = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0]
    {
        PH_HUNT    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CRC_H   = 3'd3,
        PH_CRC_L   = 3'd4
    } phase_t;

    typedef enum logic [ROLE_W-1:0]
    {
        ROLE_DISCARD = 3'd0,
        ROLE_START   = 3'd1,
        ROLE_HEADER  = 3'd2,
        ROLE_PAYLOAD = 3'd3,
        ROLE_CRC_H   = 3'd4,
        ROLE_CRC_L   = 3'd5
    } role_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ABORT = 2'd2
    } status_t;

    typedef struct packed
    {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] max_payload;
    } cfg_t;

    typedef struct packed
    {
        logic [BYTE_W-1:0] data;
        role_t             role;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] count;
        status_t           status;
    } result_t;

endpackage

`default_nettype wire

[design/lpfd_apb_regs.sv]
// APB-style configuration registers of the frame deframer.
// Depends on lpfd_pkg for widths, reset values and the config struct.
`default_nettype none

module lpfd_apb_regs
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lpfd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lpfd_pkg::DATA_W-1:0]   pwdata,
    output logic      [lpfd_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output lpfd_pkg::cfg_t                     cfg
);

    logic [lpfd_pkg::BYTE_W-1:0] start_byte_reg;
    logic [lpfd_pkg::BYTE_W-1:0] max_payload_reg;
    lpfd_pkg::reg_idx_t          idx;
    logic                        wr_en;

    assign idx    = lpfd_pkg::reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg  <= lpfd_pkg::START_BYTE_RST;
            max_payload_reg <= lpfd_pkg::MAX_PAYLOAD_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                lpfd_pkg::REG_START_BYTE:  start_byte_reg  <= pwdata[lpfd_pkg::BYTE_W-1:0];
                lpfd_pkg::REG_MAX_PAYLOAD: max_payload_reg <= pwdata[lpfd_pkg::BYTE_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            lpfd_pkg::REG_START_BYTE:
                prdata = {{(lpfd_pkg::DATA_W-lpfd_pkg::BYTE_W){1'b0}}, start_byte_reg};
            lpfd_pkg::REG_MAX_PAYLOAD:
                prdata = {{(lpfd_pkg::DATA_W-lpfd_pkg::BYTE_W){1'b0}}, max_payload_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.start_byte  = start_byte_reg;
    assign cfg.max_payload = max_payload_reg;

endmodule

`default_nettype wire

[design/lpfd_parser.sv]
// Frame parsing state machine with its result register.
// One input byte per cycle while not stalled; depends on lpfd_pkg.
`default_nettype none

module lpfd_parser
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lpfd_pkg::cfg_t                cfg,
    input  wire logic                          byte_valid,
    input  wire logic [lpfd_pkg::BYTE_W-1:0]   byte_in,
    output logic                               advance,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output lpfd_pkg::result_t                  result
);

    lpfd_pkg::phase_t            phase_reg, phase_next;
    logic [lpfd_pkg::POS_W-1:0]  position_reg, position_next;
    logic [lpfd_pkg::BYTE_W-1:0] length_reg, length_next;
    logic                        out_valid_reg;
    lpfd_pkg::result_t           result_reg, result_next;
    logic [lpfd_pkg::POS_W-1:0]  here_inc;
    logic [lpfd_pkg::BYTE_W-1:0] len_now;

    // a byte moves on when the result register is free or being emptied
    assign advance   = byte_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= lpfd_pkg::PH_HUNT;
            position_reg <= '0;
            length_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
            length_reg   <= length_next;
        end
    end

    always_comb
    begin
        here_inc      = position_reg + 1'b1;
        len_now       = length_reg;
        phase_next    = phase_reg;
        position_next = position_reg;
        length_next   = length_reg;

        result_next.data   = byte_in;
        result_next.role   = lpfd_pkg::ROLE_DISCARD;
        result_next.pos    = '0;
        result_next.count  = '0;
        result_next.status = lpfd_pkg::ST_BUSY;

        case (phase_reg)
            lpfd_pkg::PH_HEADER:
            begin
                result_next.role = lpfd_pkg::ROLE_HEADER;
                result_next.pos  = position_reg;
                if (position_reg == lpfd_pkg::LENGTH_POS)
                begin
                    len_now = byte_in;
                end
                length_next   = len_now;
                position_next = here_inc;
                if (here_inc == lpfd_pkg::HEADER_END)
                begin
                    result_next.count = len_now;
                    if (len_now > cfg.max_payload)
                    begin
                        result_next.status = lpfd_pkg::ST_ABORT;
                        phase_next         = lpfd_pkg::PH_HUNT;
                        position_next      = '0;
                    end
                    else if (len_now == '0)
                    begin
                        phase_next = lpfd_pkg::PH_CRC_H;
                    end
                    else
                    begin
                        phase_next = lpfd_pkg::PH_PAYLOAD;
                    end
                end
            end
            lpfd_pkg::PH_PAYLOAD:
            begin
                result_next.role  = lpfd_pkg::ROLE_PAYLOAD;
                result_next.pos   = position_reg;
                result_next.count = length_reg;
                position_next     = here_inc;
                if (here_inc == lpfd_pkg::HEADER_END + {1'b0, length_reg})
                begin
                    phase_next = lpfd_pkg::PH_CRC_H;
                end
            end
            lpfd_pkg::PH_CRC_H:
            begin
                result_next.role  = lpfd_pkg::ROLE_CRC_H;
                result_next.pos   = position_reg;
                result_next.count = length_reg;
                position_next     = here_inc;
                phase_next        = lpfd_pkg::PH_CRC_L;
            end
            lpfd_pkg::PH_CRC_L:
            begin
                result_next.role   = lpfd_pkg::ROLE_CRC_L;
                result_next.pos    = position_reg;
                result_next.count  = length_reg;
                result_next.status = lpfd_pkg::ST_DONE;
                phase_next         = lpfd_pkg::PH_HUNT;
                position_next      = '0;
            end
            default:
            begin
                // hunt: drop everything but the start byte
                phase_next    = lpfd_pkg::PH_HUNT;
                position_next = '0;
                if (byte_in == cfg.start_byte)
                begin
                    result_next.role = lpfd_pkg::ROLE_START;
                    length_next      = '0;
                    position_next    = {{(lpfd_pkg::POS_W-1){1'b0}}, 1'b1};
                    phase_next       = lpfd_pkg::PH_HEADER;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    a_done_is_crc_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.status == lpfd_pkg::ST_DONE
        |-> result_reg.role == lpfd_pkg::ROLE_CRC_L)
        else $error("frame complete reported on a byte other than CRC low");

    a_discard_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.role == lpfd_pkg::ROLE_DISCARD
        |-> result_reg.pos == '0 && result_reg.count == '0
            && result_reg.status == lpfd_pkg::ST_BUSY)
        else $error("discarded byte carries frame information");

    a_crc_low_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == lpfd_pkg::PH_CRC_L
        |=> phase_reg == lpfd_pkg::PH_HUNT && position_reg == '0)
        else $error("parser did not return to hunting after the frame");

    a_header_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == lpfd_pkg::PH_HEADER
        |-> position_reg != '0 && position_reg < lpfd_pkg::HEADER_END)
        else $error("header position out of range");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(result_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

[design/length_prefixed_frame_deframer.sv]
// Accepted requests pass through the input register into the result register.
// Throughput: one byte per cycle while out_stall does not hold the result.
// Both registers hold their bytes while out_stall blocks the result register.
// Reset (rst_n low, asynchronous): parser hunts for a start byte at position 0,
// no request held, start_byte = 170 and max_payload = 255.
`default_nettype none

module length_prefixed_frame_deframer
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [lpfd_pkg::BYTE_W-1:0]   rx_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [lpfd_pkg::BYTE_W-1:0]   byte_out,
    output logic      [lpfd_pkg::ROLE_W-1:0]   byte_role,
    output logic      [lpfd_pkg::POS_W-1:0]    byte_pos,
    output logic      [lpfd_pkg::BYTE_W-1:0]   payload_count,
    output logic      [lpfd_pkg::STATUS_W-1:0] frame_status,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lpfd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lpfd_pkg::DATA_W-1:0]   pwdata,
    output logic      [lpfd_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    lpfd_pkg::cfg_t              cfg;
    lpfd_pkg::result_t           result;
    logic                        in_valid_reg;
    logic [lpfd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        advance;
    logic                        in_accept;

    // the input register takes a new request when empty or as its content moves on
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    lpfd_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lpfd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .byte_valid (in_valid_reg),
        .byte_in    (in_byte_reg),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    assign byte_out      = result.data;
    assign byte_role     = result.role;
    assign byte_pos      = result.pos;
    assign payload_count = result.count;
    assign frame_status  = result.status;

endmodule

`default_nettype wire

[test/length_prefixed_frame_deframer_tb.sv]
// Self-checking testbench for length_prefixed_frame_deframer.
// Needs lpfd_pkg and the deframer RTL. Starts with a directed byte table, then
// sends random frames and stray bytes under seven register settings, with random stalls in all but the first.
`default_nettype none

module length_prefixed_frame_deframer_tb;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic [lpfd_pkg::BYTE_W-1:0]   rx_byte   = '0;
    logic                          out_stall = 1'b0;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [lpfd_pkg::ADDR_W-1:0]   paddr     = '0;
    logic [lpfd_pkg::DATA_W-1:0]   pwdata    = '0;

    logic                          in_stall;
    logic                          out_valid;
    logic [lpfd_pkg::BYTE_W-1:0]   byte_out;
    logic [lpfd_pkg::ROLE_W-1:0]   byte_role;
    logic [lpfd_pkg::POS_W-1:0]    byte_pos;
    logic [lpfd_pkg::BYTE_W-1:0]   payload_count;
    logic [lpfd_pkg::STATUS_W-1:0] frame_status;
    logic [lpfd_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    length_prefixed_frame_deframer dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Deframer state as the testbench sees it
    lpfd_pkg::phase_t            fr_phase     = lpfd_pkg::PH_HUNT;
    logic [lpfd_pkg::POS_W-1:0]  fr_pos       = '0;
    logic [lpfd_pkg::BYTE_W-1:0] fr_len       = '0;
    logic [lpfd_pkg::BYTE_W-1:0] start_mirror = lpfd_pkg::START_BYTE_RST;
    logic [lpfd_pkg::BYTE_W-1:0] max_mirror   = lpfd_pkg::MAX_PAYLOAD_RST;

    lpfd_pkg::result_t pending_tags [$];

    bit gaps_on        = 1'b0;
    int errors         = 0;
    int bytes_sent     = 0;
    int reg_writes     = 0;
    int frames_done    = 0;
    int frames_aborted = 0;
    int dropped        = 0;
    int stall_left     = 0;

    typedef struct packed
    {
        logic                        cfg;
        lpfd_pkg::reg_idx_t          idx;
        logic [lpfd_pkg::BYTE_W-1:0] val;
        logic                        typed;
        lpfd_pkg::role_t             role;
        logic [lpfd_pkg::POS_W-1:0]  pos;
        logic [lpfd_pkg::BYTE_W-1:0] cnt;
        lpfd_pkg::status_t           st;
    } step_row_t;

    step_row_t script [22] = '{
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'h00, 1'b1,
          lpfd_pkg::ROLE_DISCARD, 9'd0, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'hFF, 1'b1,
          lpfd_pkg::ROLE_DISCARD, 9'd0, 8'd0,   lpfd_pkg::ST_BUSY},
        // zero-payload frame with the start value repeated inside the header
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'hAA, 1'b1,
          lpfd_pkg::ROLE_START,   9'd0, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'h11, 1'b1,
          lpfd_pkg::ROLE_HEADER,  9'd1, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'hAA, 1'b1,
          lpfd_pkg::ROLE_HEADER,  9'd2, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'h00, 1'b0,
          lpfd_pkg::ROLE_DISCARD, 9'd0, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'hFF, 1'b0,
          lpfd_pkg::ROLE_DISCARD, 9'd0, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'h5A, 1'b0,
          lpfd_pkg::ROLE_DISCARD, 9'd0, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'hA5, 1'b0,
          lpfd_pkg::ROLE_DISCARD, 9'd0, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'h00, 1'b1,
          lpfd_pkg::ROLE_HEADER,  9'd7, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'h12, 1'b1,
          lpfd_pkg::ROLE_CRC_H,   9'd8, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'h34, 1'b1,
          lpfd_pkg::ROLE_CRC_L,   9'd9, 8'd0,   lpfd_pkg::ST_DONE},
        // length abort: the offending length equals the start value
        '{1'b1, lpfd_pkg::REG_MAX_PAYLOAD, 8'h00, 1'b0,
          lpfd_pkg::ROLE_DISCARD, 9'd0, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'hAA, 1'b1,
          lpfd_pkg::ROLE_START,   9'd0, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'hFF, 1'b0,
          lpfd_pkg::ROLE_DISCARD, 9'd0, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'h00, 1'b0,
          lpfd_pkg::ROLE_DISCARD, 9'd0, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'h80, 1'b0,
          lpfd_pkg::ROLE_DISCARD, 9'd0, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'h7F, 1'b0,
          lpfd_pkg::ROLE_DISCARD, 9'd0, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'h01, 1'b0,
          lpfd_pkg::ROLE_DISCARD, 9'd0, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'hFE, 1'b0,
          lpfd_pkg::ROLE_DISCARD, 9'd0, 8'd0,   lpfd_pkg::ST_BUSY},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'hAA, 1'b1,
          lpfd_pkg::ROLE_HEADER,  9'd7, 8'd170, lpfd_pkg::ST_ABORT},
        '{1'b0, lpfd_pkg::REG_START_BYTE,  8'h01, 1'b1,
          lpfd_pkg::ROLE_DISCARD, 9'd0, 8'd0,   lpfd_pkg::ST_BUSY}
    };

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Tag one byte and advance the frame state
    function automatic lpfd_pkg::result_t deframe_byte(input logic [lpfd_pkg::BYTE_W-1:0] b);
        lpfd_pkg::result_t          r;
        logic [lpfd_pkg::POS_W-1:0] here;
        r.data   = b;
        r.role   = lpfd_pkg::ROLE_DISCARD;
        r.pos    = '0;
        r.count  = '0;
        r.status = lpfd_pkg::ST_BUSY;
        here     = fr_pos;
        case (fr_phase)
            lpfd_pkg::PH_HEADER:
            begin
                r.role = lpfd_pkg::ROLE_HEADER;
                r.pos  = here;
                if (here == lpfd_pkg::LENGTH_POS)
                    fr_len = b;
                here = here + 1'b1;
                if (here == lpfd_pkg::HEADER_END)
                begin
                    r.count = fr_len;
                    if (fr_len > max_mirror)
                    begin
                        r.status = lpfd_pkg::ST_ABORT;
                        fr_phase = lpfd_pkg::PH_HUNT;
                        here     = '0;
                    end
                    else if (fr_len == '0)
                        fr_phase = lpfd_pkg::PH_CRC_H;
                    else
                        fr_phase = lpfd_pkg::PH_PAYLOAD;
                end
            end
            lpfd_pkg::PH_PAYLOAD:
            begin
                r.role  = lpfd_pkg::ROLE_PAYLOAD;
                r.pos   = here;
                r.count = fr_len;
                here    = here + 1'b1;
                if (here == lpfd_pkg::HEADER_END + lpfd_pkg::POS_W'(fr_len))
                    fr_phase = lpfd_pkg::PH_CRC_H;
            end
            lpfd_pkg::PH_CRC_H:
            begin
                r.role   = lpfd_pkg::ROLE_CRC_H;
                r.pos    = here;
                r.count  = fr_len;
                here     = here + 1'b1;
                fr_phase = lpfd_pkg::PH_CRC_L;
            end
            lpfd_pkg::PH_CRC_L:
            begin
                r.role   = lpfd_pkg::ROLE_CRC_L;
                r.pos    = here;
                r.count  = fr_len;
                r.status = lpfd_pkg::ST_DONE;
                fr_phase = lpfd_pkg::PH_HUNT;
                here     = '0;
            end
            default:
            begin
                fr_phase = lpfd_pkg::PH_HUNT;
                here     = '0;
                if (b == start_mirror)
                begin
                    r.role   = lpfd_pkg::ROLE_START;
                    fr_len   = '0;
                    here     = 9'd1;
                    fr_phase = lpfd_pkg::PH_HEADER;
                end
            end
        endcase
        fr_pos = here;
        return r;
    endfunction

    // Receive side: check each accepted result, then pick the next stall
    always @(posedge clk)
    begin
        lpfd_pkg::result_t want;
        int                n;
        if (out_valid && !out_stall)
        begin
            if (pending_tags.size() == 0)
            begin
                errors++;
                $error("unexpected result: byte_out %0h role %0d pos %0d",
                       byte_out, byte_role, byte_pos);
            end
            else
            begin
                want = pending_tags.pop_front();
                if (byte_out !== want.data)
                begin
                    errors++;
                    $error("byte_out: expected %0h, got %0h", want.data, byte_out);
                end
                if (byte_role !== want.role)
                begin
                    errors++;
                    $error("byte_role: expected %0d, got %0d", want.role, byte_role);
                end
                if (byte_pos !== want.pos)
                begin
                    errors++;
                    $error("byte_pos: expected %0d, got %0d", want.pos, byte_pos);
                end
                if (payload_count !== want.count)
                begin
                    errors++;
                    $error("payload_count: expected %0d, got %0d", want.count, payload_count);
                end
                if (frame_status !== want.status)
                begin
                    errors++;
                    $error("frame_status: expected %0d, got %0d", want.status, frame_status);
                end
                if (want.status == lpfd_pkg::ST_DONE)
                    frames_done++;
                if (want.status == lpfd_pkg::ST_ABORT)
                    frames_aborted++;
                if (want.role == lpfd_pkg::ROLE_DISCARD)
                    dropped++;
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            n = pick_gap();
            out_stall <= (n != 0);
            stall_left = (n != 0) ? n - 1 : 0;
        end
    end

    task automatic send_byte(input logic [lpfd_pkg::BYTE_W-1:0] b, input bit typed = 1'b0,
                             input lpfd_pkg::result_t want = '0);
        int                g;
        lpfd_pkg::result_t predicted;
        g = pick_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        predicted = deframe_byte(b);
        pending_tags.push_back(typed ? want : predicted);
        bytes_sent++;
    endtask

    // Hold the sender until every pending result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_tags.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input lpfd_pkg::reg_idx_t idx,
                             input logic [lpfd_pkg::BYTE_W-1:0] val);
        logic [lpfd_pkg::DATA_W-1:0] word;
        word      = $urandom;
        word[7:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == lpfd_pkg::REG_START_BYTE)
            start_mirror = val;
        else
            max_mirror = val;
        reg_writes++;
        @(posedge clk);
        // read back
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== lpfd_pkg::DATA_W'(val))
        begin
            errors++;
            $error("prdata: expected %0h, got %0h", lpfd_pkg::DATA_W'(val), prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_frame(input int force_len = -1);
        int                          len;
        int                          r;
        logic [lpfd_pkg::BYTE_W-1:0] b;
        r = $urandom_range(0, 99);
        if (force_len >= 0)
            len = force_len;
        else if (r < 3)
            len = 255;
        else if (r < 70)
            len = $urandom_range(0, (max_mirror < 12) ? max_mirror : 12);
        else if (r < 80)
            len = max_mirror;
        else if (r < 92)
            len = (max_mirror == 8'hFF) ? $urandom_range(0, 20) : max_mirror + 1;
        else
            len = $urandom_range(0, 40);
        send_byte(start_mirror);
        for (int k = 1; k < lpfd_pkg::HEADER_BYTES; k++)
        begin
            b = lpfd_pkg::BYTE_W'($urandom);
            if ($urandom_range(0, 9) == 0)
                b = start_mirror;
            if (k == lpfd_pkg::LENGTH_OFFSET)
                b = lpfd_pkg::BYTE_W'(len);
            send_byte(b);
        end
        if (len <= max_mirror)
        begin
            for (int k = 0; k < len + 2; k++)
            begin
                b = lpfd_pkg::BYTE_W'($urandom);
                if ($urandom_range(0, 9) == 0)
                    b = start_mirror;
                send_byte(b);
            end
        end
    endtask

    initial
    begin
        logic [lpfd_pkg::BYTE_W-1:0] phase_start [7];
        logic [lpfd_pkg::BYTE_W-1:0] phase_max [7];
        int                          first;
        int                          nframes;
        int                          r;
        phase_start = '{8'hAA, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hAA};
        phase_max   = '{8'hFF, 8'h00, 8'hFF, 8'hFE, 8'h00, 8'h01, 8'h08};
        phase_start[3] = lpfd_pkg::BYTE_W'($urandom);
        phase_start[4] = lpfd_pkg::BYTE_W'($urandom);
        phase_start[5] = lpfd_pkg::BYTE_W'($urandom);
        phase_max[4]   = lpfd_pkg::BYTE_W'($urandom);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gaps_on = 1'b1;
        foreach (script[i])
        begin
            if (script[i].cfg)
            begin
                wait_drained();
                write_reg(script[i].idx, script[i].val);
            end
            else
                send_byte(script[i].val, script[i].typed,
                          lpfd_pkg::result_t'{script[i].val, script[i].role, script[i].pos,
                                              script[i].cnt, script[i].st});
        end

        for (int p = 0; p < 7; p++)
        begin
            wait_drained();
            gaps_on = (p != 0);
            write_reg(lpfd_pkg::REG_START_BYTE, phase_start[p]);
            write_reg(lpfd_pkg::REG_MAX_PAYLOAD, phase_max[p]);
            first   = bytes_sent;
            nframes = 0;
            if (p == 2)
                send_frame(255);
            while (bytes_sent - first < 105)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    repeat ($urandom_range(1, 4)) send_byte(lpfd_pkg::BYTE_W'($urandom));
                end
                else if (r < 15)
                begin
                    // truncated frame: start and a few header bytes only
                    send_byte(start_mirror);
                    repeat ($urandom_range(1, 6)) send_byte(lpfd_pkg::BYTE_W'($urandom));
                end
                else
                begin
                    send_frame();
                    nframes++;
                end
                if (nframes == 2 || $urandom_range(0, 24) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes across %0d register writes: %0d frames completed,",
                 bytes_sent, reg_writes, frames_done);
        $display("%0d frames aborted on length, %0d bytes dropped while hunting.",
                 frames_aborted, dropped);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
design/lpfd_pkg.sv
design/lpfd_apb_regs.sv
design/lpfd_parser.sv
design/length_prefixed_frame_deframer.sv
test/length_prefixed_frame_deframer_tb.sv
